FILE: design/triangle_tangent_vector_assert.svh
// Assertion macros for the triangle tangent vector block.
// Used by modules that check their own control logic; no other dependencies.
`ifndef TRIANGLE_TANGENT_VECTOR_ASSERT_SVH
`define TRIANGLE_TANGENT_VECTOR_ASSERT_SVH

// Assertion with an explicit clock and active-low reset.
`define TTV_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the house clock and reset names.
`define TTV_ASSERT(label, prop, msg) \
  `TTV_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: design/ttv_pkg.sv
// Shared types and constants for the triangle tangent vector block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package ttv_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 32;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned TANGENT_WIDTH     = 16;

  localparam logic [1:0] CORNER_0  = 2'd0;
  localparam logic [1:0] CORNER_1  = 2'd1;
  localparam logic [1:0] CORNER_2  = 2'd2;
  localparam logic [1:0] COMP_X    = 2'd0;
  localparam logic [1:0] COMP_Y    = 2'd1;
  localparam logic [1:0] COMP_LAST = 2'd2;

  // Products taken by the shared shift-add multiplier, in issue order.
  typedef enum logic [3:0] {
    OP_DET_A, OP_DET_B,
    OP_TX_A, OP_TX_B,
    OP_TY_A, OP_TY_B,
    OP_TZ_A, OP_TZ_B,
    OP_SQ_X, OP_SQ_Y, OP_SQ_Z
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_RUN, ST_CHECK,
    ST_DIV_GO, ST_DIV_RUN, ST_SQRT_GO, ST_SQRT_RUN, ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic       take;
    logic       mul_start;
    logic       mul_step;
    logic       mul_store;
    logic       div_start;
    logic       div_step;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       res_store;
    logic       out_load;
    mul_op_e    op;
    logic [1:0] comp;
  } ttv_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic degen;
  } ttv_status_t;

endpackage

FILE: design/ttv_in_if.sv
// Corner item channel: valid/ready handshake with corner index and coordinates.
// Depends on ttv_pkg for the default coordinate width.
interface ttv_in_if #(
  parameter int unsigned COORD_WIDTH = ttv_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    corner;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] tex_u;
  logic signed [COORD_WIDTH-1:0] tex_v;

  modport source (output valid, corner, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, corner, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

FILE: design/ttv_out_if.sv
// Tangent result channel: valid/ready handshake with the Q2.14 tangent and flag.
// Depends on ttv_pkg for the tangent width.
interface ttv_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [ttv_pkg::TANGENT_WIDTH-1:0]   tangent_x;
  logic signed [ttv_pkg::TANGENT_WIDTH-1:0]   tangent_y;
  logic signed [ttv_pkg::TANGENT_WIDTH-1:0]   tangent_z;
  logic                                       degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

FILE: design/ttv_datapath.sv
// Datapath: corner store, shift-add multiplier, restoring divider, bitwise sqrt.
// Depends on ttv_pkg for command and status types.
module ttv_datapath #(
  parameter int unsigned COORD_WIDTH   = ttv_pkg::COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = ttv_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  ttv_pkg::ttv_cmd_t                        cmd_i,
  output ttv_pkg::ttv_status_t                     status_o,
  input  logic [1:0]                               corner_i,
  input  logic signed [COORD_WIDTH-1:0]            pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]            pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]            pos_z_i,
  input  logic signed [COORD_WIDTH-1:0]            tex_u_i,
  input  logic signed [COORD_WIDTH-1:0]            tex_v_i,
  output logic signed [ttv_pkg::TANGENT_WIDTH-1:0] tangent_x_o,
  output logic signed [ttv_pkg::TANGENT_WIDTH-1:0] tangent_y_o,
  output logic signed [ttv_pkg::TANGENT_WIDTH-1:0] tangent_z_o,
  output logic                                     degenerate_o
);
  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned F    = OUT_FRAC_BITS;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned CW   = 2 * W + 3;
  localparam int unsigned MW   = CW;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned XW   = PW + 2 * F;
  localparam int unsigned QW   = 2 * F + 1;
  localparam int unsigned RW   = F + 1;
  localparam int unsigned EW   = F + 17;
  localparam int unsigned TW   = ttv_pkg::TANGENT_WIDTH;
  localparam int unsigned MAXC = (MW > QW) ? MW : QW;
  localparam int unsigned CNTW = $clog2(MAXC + 1);

  logic [W-1:0] p0_q [3];
  logic [W-1:0] p1_q [3];
  logic [W-1:0] p2_q [3];
  logic [W-1:0] uv0_q [2];
  logic [W-1:0] uv1_q [2];
  logic [W-1:0] uv2_q [2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      unique case (corner_i)
        ttv_pkg::CORNER_0: begin
          p0_q[0] <= pos_x_i; p0_q[1] <= pos_y_i; p0_q[2] <= pos_z_i;
          uv0_q[0] <= tex_u_i; uv0_q[1] <= tex_v_i;
        end
        ttv_pkg::CORNER_1: begin
          p1_q[0] <= pos_x_i; p1_q[1] <= pos_y_i; p1_q[2] <= pos_z_i;
          uv1_q[0] <= tex_u_i; uv1_q[1] <= tex_v_i;
        end
        ttv_pkg::CORNER_2: begin
          p2_q[0] <= pos_x_i; p2_q[1] <= pos_y_i; p2_q[2] <= pos_z_i;
          uv2_q[0] <= tex_u_i; uv2_q[1] <= tex_v_i;
        end
        default: ;
      endcase
    end
  end

  // Edge and texture deltas
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [DW-1:0] d1u, d1v, d2u, d2v;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = DW'($signed(p1_q[k])) - DW'($signed(p0_q[k]));
      e2[k] = DW'($signed(p2_q[k])) - DW'($signed(p0_q[k]));
    end
    d1u = DW'($signed(uv1_q[0])) - DW'($signed(uv0_q[0]));
    d1v = DW'($signed(uv1_q[1])) - DW'($signed(uv0_q[1]));
    d2u = DW'($signed(uv2_q[0])) - DW'($signed(uv0_q[0]));
    d2v = DW'($signed(uv2_q[1])) - DW'($signed(uv0_q[1]));
  end

  logic signed [CW-1:0] t_q [3];
  logic signed [CW-1:0] det_q, pa_q;
  logic signed [CW-1:0] opa, opb;

  always_comb begin
    unique case (cmd_i.op)
      ttv_pkg::OP_DET_A: begin opa = CW'(d1u);   opb = CW'(d2v);   end
      ttv_pkg::OP_DET_B: begin opa = CW'(d1v);   opb = CW'(d2u);   end
      ttv_pkg::OP_TX_A:  begin opa = CW'(d2v);   opb = CW'(e1[0]); end
      ttv_pkg::OP_TX_B:  begin opa = CW'(d1v);   opb = CW'(e2[0]); end
      ttv_pkg::OP_TY_A:  begin opa = CW'(d2v);   opb = CW'(e1[1]); end
      ttv_pkg::OP_TY_B:  begin opa = CW'(d1v);   opb = CW'(e2[1]); end
      ttv_pkg::OP_TZ_A:  begin opa = CW'(d2v);   opb = CW'(e1[2]); end
      ttv_pkg::OP_TZ_B:  begin opa = CW'(d1v);   opb = CW'(e2[2]); end
      ttv_pkg::OP_SQ_X:  begin opa = t_q[0];     opb = t_q[0];     end
      ttv_pkg::OP_SQ_Y:  begin opa = t_q[1];     opb = t_q[1];     end
      ttv_pkg::OP_SQ_Z:  begin opa = t_q[2];     opb = t_q[2];     end
      default:           begin opa = '0;         opb = '0;         end
    endcase
  end

  logic [MW-1:0] mag_a, mag_b;
  assign mag_a = opa[CW-1] ? MW'(-opa) : MW'(opa);
  assign mag_b = opb[CW-1] ? MW'(-opb) : MW'(opb);

  // Shared iteration counter
  logic [CNTW-1:0] cnt_q;
  logic            unit_done;
  assign unit_done = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul_start) begin
      cnt_q <= CNTW'(MW);
    end else if (cmd_i.div_start) begin
      cnt_q <= CNTW'(QW);
    end else if (cmd_i.sqrt_start) begin
      cnt_q <= CNTW'(RW);
    end else if ((cmd_i.mul_step || cmd_i.div_step || cmd_i.sqrt_step) && !unit_done) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  // Shift-add multiplier on magnitudes; sign applied at store
  logic [PW-1:0] acc_q, mcand_q;
  logic [MW-1:0] mplier_q;
  logic          sgn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      acc_q    <= '0;
      mcand_q  <= PW'(mag_a);
      mplier_q <= mag_b;
      sgn_q    <= opa[CW-1] ^ opb[CW-1];
    end else if (cmd_i.mul_step && !unit_done) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  logic [PW-1:0]        prod_s;
  logic signed [CW-1:0] prod_c, diff;
  assign prod_s = sgn_q ? -acc_q : acc_q;
  assign prod_c = $signed(prod_s[CW-1:0]);
  assign diff   = pa_q - prod_c;

  logic [PW-1:0] sq_q [3];
  logic [PW-1:0] len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      unique case (cmd_i.op)
        ttv_pkg::OP_DET_A, ttv_pkg::OP_TX_A,
        ttv_pkg::OP_TY_A, ttv_pkg::OP_TZ_A: pa_q <= prod_c;
        ttv_pkg::OP_DET_B: det_q  <= diff;
        ttv_pkg::OP_TX_B:  t_q[0] <= det_q[CW-1] ? -diff : diff;
        ttv_pkg::OP_TY_B:  t_q[1] <= det_q[CW-1] ? -diff : diff;
        ttv_pkg::OP_TZ_B:  t_q[2] <= det_q[CW-1] ? -diff : diff;
        ttv_pkg::OP_SQ_X: begin sq_q[0] <= acc_q; len_q <= acc_q;         end
        ttv_pkg::OP_SQ_Y: begin sq_q[1] <= acc_q; len_q <= len_q + acc_q; end
        ttv_pkg::OP_SQ_Z: begin sq_q[2] <= acc_q; len_q <= len_q + acc_q; end
        default: ;
      endcase
    end
  end

  // Restoring divider: quotient of square * 2^(2F) over squared length
  logic [XW-1:0] rem_q, dvs_q;
  logic [QW-1:0] quo_q;
  logic          rem_ge;
  assign rem_ge = (rem_q >= dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= {sq_q[cmd_i.comp], {(2 * F){1'b0}}};
      dvs_q <= {len_q, {(2 * F){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step && !unit_done) begin
      if (rem_ge) rem_q <= rem_q - dvs_q;
      quo_q <= {quo_q[QW-2:0], rem_ge};
      dvs_q <= dvs_q >> 1;
    end
  end

  // Bitwise integer square root of the quotient
  logic [RW-1:0]     root_q, sbit_q, trial;
  logic [2*RW-1:0]   trial_sq;
  assign trial    = root_q | sbit_q;
  assign trial_sq = (2 * RW)'(trial) * (2 * RW)'(trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      root_q <= '0;
      sbit_q <= {1'b1, {(RW - 1){1'b0}}};
    end else if (cmd_i.sqrt_step && !unit_done) begin
      if (trial_sq <= (2 * RW)'(quo_q)) root_q <= trial;
      sbit_q <= sbit_q >> 1;
    end
  end

  logic [EW-1:0] root_x, root_s;
  assign root_x = EW'(root_q);
  assign root_s = t_q[cmd_i.comp][CW-1] ? -root_x : root_x;

  logic [TW-1:0] res_q [3];
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_store) res_q[cmd_i.comp] <= root_s[TW-1:0];
  end

  logic degen;
  assign degen = (det_q == '0) || (len_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tangent_x_o  <= degen ? '0 : $signed(res_q[0]);
      tangent_y_o  <= degen ? '0 : $signed(res_q[1]);
      tangent_z_o  <= degen ? '0 : $signed(res_q[2]);
      degenerate_o <= degen;
    end
  end

  assign status_o.unit_done = unit_done;
  assign status_o.degen     = degen;
endmodule

FILE: design/ttv_ctrl.sv
// Controller: sequences corner intake, products, divisions and square roots.
// Depends on ttv_pkg and the assertion macro header.
`include "triangle_tangent_vector_assert.svh"

module ttv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           corner_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ttv_pkg::ttv_cmd_t    cmd_o,
  input  ttv_pkg::ttv_status_t status_i
);
  ttv_pkg::ctrl_state_e state_q, state_d;
  ttv_pkg::mul_op_e     op_q, op_d;
  logic [1:0]           comp_q, comp_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttv_pkg::ST_IDLE;
      op_q        <= ttv_pkg::OP_DET_A;
      comp_q      <= ttv_pkg::COMP_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    comp_d     = comp_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    cmd_o.comp = comp_q;
    in_ready_o = 1'b0;

    unique case (state_q)
      ttv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (corner_i == ttv_pkg::CORNER_2) begin
            op_d    = ttv_pkg::OP_DET_A;
            state_d = ttv_pkg::ST_MUL_GO;
          end
        end
      end
      ttv_pkg::ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ttv_pkg::ST_MUL_RUN;
      end
      ttv_pkg::ST_MUL_RUN: begin
        if (!status_i.unit_done) begin
          cmd_o.mul_step = 1'b1;
        end else begin
          cmd_o.mul_store = 1'b1;
          if (op_q == ttv_pkg::OP_SQ_Z) begin
            comp_d  = ttv_pkg::COMP_X;
            state_d = ttv_pkg::ST_CHECK;
          end else begin
            op_d    = ttv_pkg::mul_op_e'(op_q + 4'd1);
            state_d = ttv_pkg::ST_MUL_GO;
          end
        end
      end
      ttv_pkg::ST_CHECK: begin
        // skip normalization on a flat mapping or a null tangent
        state_d = status_i.degen ? ttv_pkg::ST_FIN : ttv_pkg::ST_DIV_GO;
      end
      ttv_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ttv_pkg::ST_DIV_RUN;
      end
      ttv_pkg::ST_DIV_RUN: begin
        if (!status_i.unit_done) cmd_o.div_step = 1'b1;
        else state_d = ttv_pkg::ST_SQRT_GO;
      end
      ttv_pkg::ST_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ttv_pkg::ST_SQRT_RUN;
      end
      ttv_pkg::ST_SQRT_RUN: begin
        if (!status_i.unit_done) begin
          cmd_o.sqrt_step = 1'b1;
        end else begin
          cmd_o.res_store = 1'b1;
          if (comp_q == ttv_pkg::COMP_LAST) begin
            state_d = ttv_pkg::ST_FIN;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = ttv_pkg::ST_DIV_GO;
          end
        end
      end
      ttv_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ttv_pkg::ST_IDLE;
        end
      end
      default: state_d = ttv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  `TTV_ASSERT(a_load_free, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `TTV_ASSERT(a_load_shows, cmd_o.out_load |=> out_valid_q, "loaded result not shown")
  `TTV_ASSERT(a_idle_quiet, in_ready_o |-> !(cmd_o.mul_step || cmd_o.div_step || cmd_o.sqrt_step), "unit runs while taking items")
  `TTV_ASSERT(a_store_done, cmd_o.mul_store |-> status_i.unit_done, "product stored before done")
endmodule

FILE: design/triangle_tangent_vector.sv
// Corners 0 and 1 are only stored; corner 2 also starts the computation, paced by the
// one-bit-a-cycle shift-add multiplier, the restoring divider and the sqrt unit.
// A degenerate triangle skips normalization (the divider and the sqrt unit).
// A finished result waits in the output register while the next corners come in.
// Reset (async, active low) clears the controller and output valid; held corners stay.
module triangle_tangent_vector #(
  parameter int unsigned COORD_WIDTH   = ttv_pkg::COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = ttv_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ttv_in_if.sink    in_i,
  ttv_out_if.source out_o
);
  ttv_pkg::ttv_cmd_t    cmd;
  ttv_pkg::ttv_status_t status;

  // Controller: handshakes and the step sequence
  ttv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .corner_i    (in_i.corner),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath: held corners, arithmetic units and result registers
  ttv_datapath #(
    .COORD_WIDTH   (COORD_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .corner_i     (in_i.corner),
    .pos_x_i      (in_i.pos_x),
    .pos_y_i      (in_i.pos_y),
    .pos_z_i      (in_i.pos_z),
    .tex_u_i      (in_i.tex_u),
    .tex_v_i      (in_i.tex_v),
    .tangent_x_o  (out_o.tangent_x),
    .tangent_y_o  (out_o.tangent_y),
    .tangent_z_o  (out_o.tangent_z),
    .degenerate_o (out_o.degenerate)
  );
endmodule
